/* hw/rtl/mrd_pkg.sv */
// ---------------------------------------------------------------------------
// mrd_pkg - shared types and constants of the MQTT receive deframer
// Parse phases, result record and fixed field widths.
// ---------------------------------------------------------------------------
package mrd_pkg;

    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int LEN_W   = 28;
    localparam int CNT_W   = 3;
    localparam int DATA_W  = 80;
    localparam int USER_W  = 2;

    localparam logic [TYPE_W-1:0] TYPE_CONNACK   = 4'd2;
    localparam logic [BYTE_W-1:0] CODE_NONE      = 8'hFF;
    localparam logic [CNT_W-1:0]  LEN_BYTES_MAX  = 3'd4;
    localparam logic [LEN_W-1:0]  CONNACK_RC_IDX = 28'd1;

    typedef enum logic [1:0] {
        PHASE_HEADER  = 2'd0,
        PHASE_LENGTH  = 2'd1,
        PHASE_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] return_code;
        logic [LEN_W-1:0]  remaining_length;
        logic [LEN_W-1:0]  payload_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [TYPE_W-1:0] packet_type;
        logic              packet_done;
        logic              length_error;
        logic              payload_valid;
    } result_t;

endpackage

/* hw/rtl/mrd_in_stage.sv */
// ---------------------------------------------------------------------------
// mrd_in_stage - input register
// Holds one received byte until the parse stage takes it.
// ---------------------------------------------------------------------------
module mrd_in_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mrd_pkg::BYTE_W-1:0] s_tdata,
    output logic                       byte_valid,
    output logic [mrd_pkg::BYTE_W-1:0] byte_data,
    input  logic                       byte_take
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [mrd_pkg::BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || byte_take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !byte_take);
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

/* hw/rtl/mrd_parser.sv */
// ---------------------------------------------------------------------------
// mrd_parser - fixed header parser
// Walks header, varint length and payload; one byte per advance.
// ---------------------------------------------------------------------------
module mrd_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [mrd_pkg::BYTE_W-1:0] rx_byte,
    output mrd_pkg::result_t           result
);

    mrd_pkg::phase_t                 phase_reg;
    mrd_pkg::phase_t                 phase_next;
    logic [mrd_pkg::TYPE_W-1:0]      type_reg;
    logic [mrd_pkg::TYPE_W-1:0]      type_next;
    logic [mrd_pkg::LEN_W-1:0]       accum_reg;
    logic [mrd_pkg::LEN_W-1:0]       accum_next;
    logic [mrd_pkg::CNT_W-1:0]       count_reg;
    logic [mrd_pkg::CNT_W-1:0]       count_next;
    logic [mrd_pkg::LEN_W-1:0]       pcount_reg;
    logic [mrd_pkg::LEN_W-1:0]       pcount_next;
    logic [mrd_pkg::BYTE_W-1:0]      code_reg;
    logic [mrd_pkg::BYTE_W-1:0]      code_next;

    logic [mrd_pkg::LEN_W-1:0]       group_shifted;
    logic [mrd_pkg::LEN_W-1:0]       accum_sum;
    logic [mrd_pkg::CNT_W-1:0]       count_inc;
    logic [mrd_pkg::LEN_W:0]         pcount_inc;
    logic                            more_bytes;
    logic                            len_overrun;
    logic                            payload_last;

    always_comb
    begin
        unique case (count_reg[1:0])
            2'd0:    group_shifted = {21'd0, rx_byte[6:0]};
            2'd1:    group_shifted = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    group_shifted = {7'd0, rx_byte[6:0], 14'd0};
            default: group_shifted = {rx_byte[6:0], 21'd0};
        endcase
    end

    assign accum_sum    = (count_reg < mrd_pkg::LEN_BYTES_MAX) ? accum_reg + group_shifted
                                                               : accum_reg;
    assign count_inc    = count_reg + 3'd1;
    assign more_bytes   = rx_byte[7];
    assign len_overrun  = count_inc >= mrd_pkg::LEN_BYTES_MAX;
    assign pcount_inc   = {1'b0, pcount_reg} + {{mrd_pkg::LEN_W{1'b0}}, 1'b1};
    assign payload_last = pcount_inc >= {1'b0, accum_reg};

    always_comb
    begin
        unique case (phase_reg)
            mrd_pkg::PHASE_LENGTH:
            begin
                if (more_bytes)
                begin
                    phase_next = len_overrun ? mrd_pkg::PHASE_HEADER : mrd_pkg::PHASE_LENGTH;
                end
                else if (accum_sum == '0)
                begin
                    phase_next = mrd_pkg::PHASE_HEADER;
                end
                else
                begin
                    phase_next = mrd_pkg::PHASE_PAYLOAD;
                end
            end
            mrd_pkg::PHASE_PAYLOAD:
            begin
                phase_next = payload_last ? mrd_pkg::PHASE_HEADER : mrd_pkg::PHASE_PAYLOAD;
            end
            default:
            begin
                phase_next = mrd_pkg::PHASE_LENGTH;
            end
        endcase
    end

    always_comb
    begin
        type_next   = type_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        pcount_next = pcount_reg;
        code_next   = code_reg;
        result      = '0;
        unique case (phase_reg)
            mrd_pkg::PHASE_LENGTH:
            begin
                accum_next          = accum_sum;
                count_next          = count_inc;
                result.length_error = more_bytes && len_overrun;
                result.packet_done  = !more_bytes && (accum_sum == '0);
                if (!more_bytes && (accum_sum != '0))
                begin
                    pcount_next = '0;
                end
            end
            mrd_pkg::PHASE_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = pcount_reg;
                result.packet_done   = payload_last;
                pcount_next          = pcount_inc[mrd_pkg::LEN_W-1:0];
                if (type_reg == mrd_pkg::TYPE_CONNACK && pcount_reg == mrd_pkg::CONNACK_RC_IDX)
                begin
                    code_next = rx_byte;
                end
            end
            default:
            begin
                type_next   = rx_byte[7:4];
                accum_next  = '0;
                count_next  = '0;
                pcount_next = '0;
                code_next   = mrd_pkg::CODE_NONE;
            end
        endcase
        result.packet_type      = type_next;
        result.remaining_length = accum_next;
        result.return_code      = code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mrd_pkg::PHASE_HEADER;
            type_reg   <= '0;
            accum_reg  <= '0;
            count_reg  <= '0;
            pcount_reg <= '0;
            code_reg   <= mrd_pkg::CODE_NONE;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            pcount_reg <= pcount_next;
            code_reg   <= code_next;
        end
    end

endmodule

/* hw/rtl/mrd_out_stage.sv */
// ---------------------------------------------------------------------------
// mrd_out_stage - result register
// Holds one parsed result beat until the downstream side takes it.
// ---------------------------------------------------------------------------
module mrd_out_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       res_valid,
    output logic                       res_ready,
    input  mrd_pkg::result_t           res,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mrd_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [mrd_pkg::USER_W-1:0] m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    mrd_pkg::result_t res_reg;

    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !m_tready);

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.return_code, res_reg.remaining_length,
                       res_reg.payload_index, res_reg.payload_byte, res_reg.packet_type};
    assign m_tlast  = res_reg.packet_done;
    assign m_tuser  = {res_reg.length_error, res_reg.payload_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

endmodule

/* hw/rtl/mqtt_receive_deframer_unit.sv */
// ---------------------------------------------------------------------------
// mqtt_receive_deframer_unit - MQTT receive deframer
// Parses the fixed header of a received MQTT byte stream and emits one
// result beat per received byte.
//
// Input channel s_*: one received byte per beat.
// Output channel m_*: one result beat per input beat, in order. tlast marks
// the final byte of a packet; tuser carries the payload and error flags.
// Path: an accepted byte is held in the input register, then the parse
// logic writes its result into the result register.
// Throughput: one byte per cycle while m_tready is high; the parser steps its
// header/length/payload state per byte, so back-to-back bytes never wait.
// Reset: the parser waits for a header byte, length and counts are zero,
// the return code reads 0xFF, and both stage registers are empty.
// Stall: while m_tready is low the result beat holds, the parser stops
// and the input register fills; s_tready falls once both are occupied.
// ---------------------------------------------------------------------------
module mqtt_receive_deframer_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mrd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [3:0] packet_type, [11:4] payload_byte, [39:12] payload_index,
    // [67:40] remaining_length, [75:68] return_code, [79:76] zero
    output logic [mrd_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast,   // packet_done
    output logic [mrd_pkg::USER_W-1:0] m_tuser    // [0] payload_valid, [1] length_error
);

    logic                       byte_valid;
    logic [mrd_pkg::BYTE_W-1:0] byte_data;
    logic                       res_ready;
    logic                       advance;
    mrd_pkg::result_t           res;

    assign advance = byte_valid && res_ready;

    mrd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (advance)
    );

    mrd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (byte_data),
        .result  (res)
    );

    mrd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (byte_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
